/* sv/dgmuf_pkg.sv */
// Shared constants for the DG Maxwell upwind surface flux block.
`timescale 1ns / 1ps

package dgmuf_pkg;

    localparam int WORD_W  = 48;  // packed three-component input word
    localparam int NORM_W  = 16;  // normal and boundary factor, Q1.14
    localparam int SCALE_W = 24;  // face scale, unsigned Q12.12
    localparam int OUT_W   = 24;  // flux, signed Q11.12
    localparam int FRAC_N  = 14;  // fraction bits of normal and factor
    localparam int FRAC_S  = 12;  // fraction bits of face scale

endpackage

/* sv/dgmuf_jump.sv */
// Four-stage scaled field jump: optional factor on outer value, difference, scale.
`timescale 1ns / 1ps

module dgmuf_jump #(
    parameter int FB = 16
) (
    input  logic                                 i_clk,
    input  logic signed [FB-1:0]                 i_outer,
    input  logic signed [FB-1:0]                 i_inner,
    input  logic signed [dgmuf_pkg::NORM_W-1:0]  i_factor,
    input  logic                                 i_apply,
    input  logic        [dgmuf_pkg::SCALE_W-1:0] i_scale,
    output logic signed [FB+15:0]                o_jump
);
    import dgmuf_pkg::*;

    localparam int PRW = FB + NORM_W;
    localparam int XW  = FB + 3;
    localparam int SPW = XW + SCALE_W + 1;
    localparam int JW  = FB + 16;

    logic signed [PRW-1:0]     r_prod;
    logic signed [FB-1:0]      r_outer;
    logic signed [FB-1:0]      r_inner;
    logic                      r_apply;
    logic        [SCALE_W-1:0] r_scale1;
    logic        [SCALE_W-1:0] r_scale2;
    logic signed [XW-1:0]      r_diff;
    logic signed [SPW-1:0]     r_sprod;
    logic signed [JW-1:0]      r_jump;

    logic signed [XW-1:0]      n_diff;
    logic signed [XW-1:0]      w_outer_adj;

    always_comb begin
        if (r_apply) begin
            w_outer_adj = XW'((r_prod + PRW'(2**(FRAC_N-1))) >>> FRAC_N);
        end else begin
            w_outer_adj = XW'(r_outer);
        end
        n_diff = w_outer_adj - XW'(r_inner);
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= i_factor * i_outer;
        r_outer  <= i_outer;
        r_inner  <= i_inner;
        r_apply  <= i_apply;
        r_scale1 <= i_scale;
        r_diff   <= n_diff;
        r_scale2 <= r_scale1;
        r_sprod  <= $signed({1'b0, r_scale2}) * r_diff;
        r_jump   <= JW'((r_sprod + SPW'(2**(FRAC_S-1))) >>> FRAC_S);
    end

    assign o_jump = r_jump;

endmodule

/* sv/dg_maxwell_upwind_surface_flux.sv */
// Upwind surface flux per DG face node: six jumps, normal projections, saturated flux.
// The strobe o_valid is start carried through the valid shift register r_vld, in step with the data registers.
// Throughput: one node per cycle; busy is held low, every stage is a fixed register step.
// The pipeline depth is set by the factor, scale, normal and projection multiply stages.
// Reset (synchronous, active low) clears only the valid bits; data registers keep running.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module dg_maxwell_upwind_surface_flux #(
    parameter int FIELD_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic        [dgmuf_pkg::WORD_W-1:0]  i_minus_magnetic,
    input  logic        [dgmuf_pkg::WORD_W-1:0]  i_minus_electric,
    input  logic        [dgmuf_pkg::WORD_W-1:0]  i_plus_magnetic,
    input  logic        [dgmuf_pkg::WORD_W-1:0]  i_plus_electric,
    input  logic        [dgmuf_pkg::WORD_W-1:0]  i_face_normal,
    input  logic        [dgmuf_pkg::SCALE_W-1:0] i_face_scale,
    input  logic signed [dgmuf_pkg::NORM_W-1:0]  i_boundary_factor,
    input  logic                                 i_remote_neighbour,
    output logic                                 o_valid,
    output logic signed [dgmuf_pkg::OUT_W-1:0]   o_flux_hx,
    output logic signed [dgmuf_pkg::OUT_W-1:0]   o_flux_hy,
    output logic signed [dgmuf_pkg::OUT_W-1:0]   o_flux_hz,
    output logic signed [dgmuf_pkg::OUT_W-1:0]   o_flux_ex,
    output logic signed [dgmuf_pkg::OUT_W-1:0]   o_flux_ey,
    output logic signed [dgmuf_pkg::OUT_W-1:0]   o_flux_ez
);
    import dgmuf_pkg::*;

    localparam int FB     = FIELD_BITS;
    localparam int PACK_W = (3 * FB > WORD_W) ? 3 * FB : WORD_W;
    localparam int DW     = FB + 16;
    localparam int PW     = NORM_W + DW;
    localparam int SW     = PW + 2;
    localparam int HW     = SW - FRAC_N;
    localparam int QW     = HW + NORM_W;
    localparam int FW     = QW + 2;
    localparam int RW     = FW - FRAC_N;
    localparam int DEPTH  = 8;
    localparam int NDEPTH = 6;

    logic [PACK_W-1:0] w_hm;
    logic [PACK_W-1:0] w_em;
    logic [PACK_W-1:0] w_hp;
    logic [PACK_W-1:0] w_ep;

    logic signed [DW-1:0] w_d [0:5];

    logic [DEPTH-1:0]  r_vld;
    logic [WORD_W-1:0] r_npipe [0:NDEPTH-1];

    logic signed [NORM_W-1:0] w_n3 [0:2];
    logic signed [NORM_W-1:0] w_n5 [0:2];

    logic signed [PW-1:0] r_p [0:2][0:5];
    logic signed [DW-1:0] r_d5 [0:5];
    logic signed [SW-1:0] r_part6 [0:5];
    logic signed [SW-1:0] r_part7 [0:5];
    logic signed [HW-1:0] r_ndh;
    logic signed [HW-1:0] r_nde;
    logic signed [QW-1:0] r_q [0:5];

    logic signed [SW-1:0] n_part [0:5];
    logic signed [SW-1:0] n_sum_h;
    logic signed [SW-1:0] n_sum_e;

    logic signed [FW-1:0]    w_fl [0:5];
    logic signed [RW-1:0]    w_rnd [0:5];
    logic signed [OUT_W-1:0] n_flux [0:5];
    logic signed [OUT_W-1:0] r_flux [0:5];

    assign busy = 1'b0;

    assign w_hm = PACK_W'(i_minus_magnetic);
    assign w_em = PACK_W'(i_minus_electric);
    assign w_hp = PACK_W'(i_plus_magnetic);
    assign w_ep = PACK_W'(i_plus_electric);

    // jumps: index 0..2 magnetic, 3..5 electric
    for (genvar gi = 0; gi < 3; gi++) begin : g_jump
        dgmuf_jump #(
            .FB(FB)
        ) u_jump_h (
            .i_clk   (i_clk),
            .i_outer ($signed(w_hp[gi*FB +: FB])),
            .i_inner ($signed(w_hm[gi*FB +: FB])),
            .i_factor(i_boundary_factor),
            .i_apply (1'b0),
            .i_scale (i_face_scale),
            .o_jump  (w_d[gi])
        );

        dgmuf_jump #(
            .FB(FB)
        ) u_jump_e (
            .i_clk   (i_clk),
            .i_outer ($signed(w_ep[gi*FB +: FB])),
            .i_inner ($signed(w_em[gi*FB +: FB])),
            .i_factor(i_boundary_factor),
            .i_apply (~i_remote_neighbour),
            .i_scale (i_face_scale),
            .o_jump  (w_d[gi+3])
        );

        assign w_n3[gi] = $signed(r_npipe[3][gi*NORM_W +: NORM_W]);
        assign w_n5[gi] = $signed(r_npipe[5][gi*NORM_W +: NORM_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], start & ~busy};
        end
    end

    always_comb begin
        n_part[0] = SW'(r_p[2][4]) - SW'(r_p[1][5]) + (SW'(r_d5[0]) <<< FRAC_N);
        n_part[1] = SW'(r_p[0][5]) - SW'(r_p[2][3]) + (SW'(r_d5[1]) <<< FRAC_N);
        n_part[2] = SW'(r_p[1][3]) - SW'(r_p[0][4]) + (SW'(r_d5[2]) <<< FRAC_N);
        n_part[3] = SW'(r_p[1][2]) - SW'(r_p[2][1]) + (SW'(r_d5[3]) <<< FRAC_N);
        n_part[4] = SW'(r_p[2][0]) - SW'(r_p[0][2]) + (SW'(r_d5[4]) <<< FRAC_N);
        n_part[5] = SW'(r_p[0][1]) - SW'(r_p[1][0]) + (SW'(r_d5[5]) <<< FRAC_N);
        n_sum_h = SW'(r_p[0][0]) + SW'(r_p[1][1]) + SW'(r_p[2][2])
                + SW'(2**(FRAC_N-1));
        n_sum_e = SW'(r_p[0][3]) + SW'(r_p[1][4]) + SW'(r_p[2][5])
                + SW'(2**(FRAC_N-1));
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_fl[k]  = FW'(r_part7[k]) - FW'(r_q[k]) + FW'(2**(FRAC_N-1));
            w_rnd[k] = RW'(w_fl[k] >>> FRAC_N);
            if ((&w_rnd[k][RW-1:OUT_W-1]) || !(|w_rnd[k][RW-1:OUT_W-1])) begin
                n_flux[k] = w_rnd[k][OUT_W-1:0];
            end else if (w_rnd[k][RW-1]) begin
                n_flux[k] = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                n_flux[k] = {1'b0, {(OUT_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_npipe[0] <= i_face_normal;
        for (int s = 1; s < NDEPTH; s++) begin
            r_npipe[s] <= r_npipe[s-1];
        end
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 6; b++) begin
                r_p[a][b] <= w_n3[a] * w_d[b];
            end
        end
        for (int k = 0; k < 6; k++) begin
            r_d5[k]    <= w_d[k];
            r_part6[k] <= n_part[k];
            r_part7[k] <= r_part6[k];
            r_flux[k]  <= n_flux[k];
        end
        r_ndh <= HW'(n_sum_h >>> FRAC_N);
        r_nde <= HW'(n_sum_e >>> FRAC_N);
        for (int a = 0; a < 3; a++) begin
            r_q[a]   <= r_ndh * w_n5[a];
            r_q[a+3] <= r_nde * w_n5[a];
        end
    end

    assign o_valid   = r_vld[DEPTH-1];
    assign o_flux_hx = r_flux[0];
    assign o_flux_hy = r_flux[1];
    assign o_flux_hz = r_flux[2];
    assign o_flux_ex = r_flux[3];
    assign o_flux_ey = r_flux[4];
    assign o_flux_ez = r_flux[5];

endmodule
